### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/wls_pkg.sv
package wls_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 64;
   localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
   localparam int RAM_DEPTH   = 2 * MAX_ENTRIES;

   // Field widths
   localparam int WEIGHT_W    = 15;
   localparam int WEIGHT_IN_W = 16;
   localparam int COUNT_W     = 7;
   localparam int SUM_W       = WEIGHT_W + COUNT_W;
   localparam int RAND_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int MODE_W      = 2;
   localparam int CMD_W       = 2;
   localparam int MOD_STEP_W  = $clog2(RAND_W);

   // Channel layout
   localparam int REQ_DATA_W     = 56;
   localparam int REQ_USER_W     = 3;
   localparam int RSP_DATA_W     = 8;
   localparam int RSP_USER_W     = 2;
   localparam int REQ_IDX_LSB    = 0;
   localparam int REQ_WEIGHT_LSB = INDEX_W;
   localparam int REQ_RAND_LSB   = INDEX_W + WEIGHT_IN_W;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

   // Selection modes
   localparam logic [MODE_W-1:0] MODE_UNIFORM  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEQ      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SELECT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRIMARY_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHTED_COUNT = 2'd2;

   typedef logic [ENTRY_AW-1:0]   entry_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [SUM_W-1:0]      sum_type;
   typedef logic [WEIGHT_W-1:0]   weight_type;
   typedef logic [RAND_W-1:0]     rand_type;
   typedef logic [INDEX_W-1:0]    index_type;
   typedef logic [MOD_STEP_W-1:0] mod_step_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SUM,
      ST_SUM_LAST,
      ST_CHECK,
      ST_MOD_W,
      ST_WALK,
      ST_WALK_LAST,
      ST_MOD_C,
      ST_RESULT
   } state_type;

   // Operand pairs for the remainder unit
   typedef enum logic [1:0] {
      MOD_POS_COUNT,
      MOD_RAND_COUNT,
      MOD_RAND_TOTAL
   } mod_src_type;

   typedef struct packed {
      logic        latch;
      logic        ram_write;
      logic        walk_clear;
      logic        rd_issue;
      logic        mod_start;
      mod_src_type mod_src;
      logic        res_miss;
      logic        res_rem;
      logic        res_hit;
      logic        pos_from_rem;
      logic        pos_restore;
      logic        rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [MODE_W-1:0] mode;
      logic              count_zero;
      logic              total_zero;
      logic              walk_last;
      logic              hit;
      logic              mod_busy;
      logic              out_free;
   } ctl_status_type;

   // Saturate a count register at the table depth
   function automatic count_type clamp_count(input logic [COUNT_W-1:0] c);
      count_type r;
      if (int'(c) > MAX_ENTRIES) begin
         r = count_type'(MAX_ENTRIES);
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

### rtl/wls_ram.sv
module wls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wls_mod.sv
module wls_mod (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  wls_pkg::rand_type dividend,
   input  wls_pkg::sum_type  divisor,
   output logic              busy,
   output wls_pkg::sum_type  remainder
);

   logic                  busy_ff, busy_in;
   wls_pkg::mod_step_type step_ff, step_in;
   wls_pkg::rand_type     shift_ff, shift_in;
   wls_pkg::sum_type      rem_ff, rem_in;
   wls_pkg::sum_type      div_ff, div_in;
   logic [wls_pkg::SUM_W:0] trial;

   // One restoring remainder step per cycle, most significant bit first
   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, shift_ff[wls_pkg::RAND_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = wls_pkg::mod_step_type'(wls_pkg::RAND_W - 1);
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[wls_pkg::RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = wls_pkg::sum_type'(trial - {1'b0, div_ff});
         end else begin
            rem_in = wls_pkg::sum_type'(trial);
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - wls_pkg::mod_step_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

### rtl/wls_dp.sv
module wls_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [wls_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [wls_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              csr_valid,
   input  logic [wls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wls_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [wls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [wls_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  wls_pkg::ctl_cmd_type              ctl,
   output wls_pkg::ctl_status_type           stat
);

   // Configuration
   logic [wls_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [wls_pkg::COUNT_W-1:0] pcount_ff, pcount_in;
   logic [wls_pkg::COUNT_W-1:0] wcount_ff, wcount_in;

   // Held transaction
   logic [wls_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic                            lsel_ff, lsel_in;
   wls_pkg::index_type              idx_ff, idx_in;
   logic [wls_pkg::WEIGHT_IN_W-1:0] weight_ff, weight_in;
   wls_pkg::rand_type               rand_ff, rand_in;

   // Walk and round robin state
   wls_pkg::entry_type pos_ff, pos_in;
   wls_pkg::count_type walk_ff, walk_in;
   wls_pkg::count_type rd_idx_ff, rd_idx_in;
   logic               rd_pend_ff, rd_pend_in;
   wls_pkg::sum_type   acc_ff, acc_in;

   // Result and output register
   logic               res_valid_ff, res_valid_in;
   logic               res_list_ff, res_list_in;
   wls_pkg::index_type res_index_ff, res_index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pick_ff, rsp_pick_in;
   logic               rsp_list_ff, rsp_list_in;
   wls_pkg::index_type rsp_index_ff, rsp_index_in;

   logic                    active_weighted;
   wls_pkg::count_type      active_count;
   wls_pkg::count_type      pcount_clamped;
   wls_pkg::count_type      wcount_clamped;
   logic [wls_pkg::ENTRY_AW:0] wr_addr;
   logic [wls_pkg::ENTRY_AW:0] rd_addr;
   wls_pkg::weight_type     wr_weight;
   wls_pkg::weight_type     rd_weight;
   logic                    wr_en;
   wls_pkg::sum_type        acc_next;
   wls_pkg::sum_type        mod_rem;
   wls_pkg::rand_type       mod_dividend;
   wls_pkg::sum_type        mod_divisor;
   logic                    mod_busy;
   wls_pkg::count_type      rem_next;
   wls_pkg::count_type      idx_next;

   // Choose the active list
   always_comb begin
      pcount_clamped  = wls_pkg::clamp_count(pcount_ff);
      wcount_clamped  = wls_pkg::clamp_count(wcount_ff);
      active_weighted = (mode_ff == wls_pkg::MODE_WEIGHTED) && (wcount_clamped != '0);
      active_count    = active_weighted ? wcount_clamped : pcount_clamped;
   end

   // Weight table: primary list in the lower half, weighted list in the upper
   assign wr_en     = ctl.ram_write && (int'(idx_ff) < wls_pkg::MAX_ENTRIES);
   assign wr_addr   = {lsel_ff, wls_pkg::entry_type'(idx_ff)};
   assign wr_weight = weight_ff[wls_pkg::WEIGHT_IN_W-1] ? '0 :
                      weight_ff[wls_pkg::WEIGHT_W-1:0];
   assign rd_addr   = {active_weighted, wls_pkg::entry_type'(walk_ff)};

   wls_ram #(
      .WIDTH (wls_pkg::WEIGHT_W),
      .DEPTH (wls_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_weight),
      .rd_en   (ctl.rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_weight)
   );

   // Pick the remainder operands
   always_comb begin
      case (ctl.mod_src)
         wls_pkg::MOD_POS_COUNT: begin
            mod_dividend = wls_pkg::rand_type'(pos_ff);
            mod_divisor  = wls_pkg::sum_type'(active_count);
         end
         wls_pkg::MOD_RAND_COUNT: begin
            mod_dividend = rand_ff;
            mod_divisor  = wls_pkg::sum_type'(active_count);
         end
         wls_pkg::MOD_RAND_TOTAL: begin
            mod_dividend = rand_ff;
            mod_divisor  = acc_ff;
         end
         default: begin
            mod_dividend = rand_ff;
            mod_divisor  = acc_ff;
         end
      endcase
   end

   wls_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   // Running sum over the table and the lottery hit test
   assign acc_next = acc_ff + wls_pkg::sum_type'(rd_weight);
   assign rem_next = wls_pkg::count_type'(mod_rem) + wls_pkg::count_type'(1);
   assign idx_next = wls_pkg::count_type'(idx_ff) + wls_pkg::count_type'(1);

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.mode       = mode_ff;
      stat.count_zero = (active_count == '0);
      stat.total_zero = (acc_ff == '0);
      stat.walk_last  = (walk_ff == active_count - wls_pkg::count_type'(1));
      stat.hit        = rd_pend_ff && (acc_next > mod_rem);
      stat.mod_busy   = mod_busy;
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // Next values of the datapath registers
   always_comb begin
      mode_in      = mode_ff;
      pcount_in    = pcount_ff;
      wcount_in    = wcount_ff;
      cmd_in       = cmd_ff;
      lsel_in      = lsel_ff;
      idx_in       = idx_ff;
      weight_in    = weight_ff;
      rand_in      = rand_ff;
      pos_in       = pos_ff;
      walk_in      = walk_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = ctl.rd_issue;
      acc_in       = acc_ff;
      res_valid_in = res_valid_ff;
      res_list_in  = res_list_ff;
      res_index_in = res_index_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pick_in  = rsp_pick_ff;
      rsp_list_in  = rsp_list_ff;
      rsp_index_in = rsp_index_ff;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            wls_pkg::REG_SELECT_MODE:    mode_in   = csr_data[wls_pkg::MODE_W-1:0];
            wls_pkg::REG_PRIMARY_COUNT:  pcount_in = csr_data[wls_pkg::COUNT_W-1:0];
            wls_pkg::REG_WEIGHTED_COUNT: wcount_in = csr_data[wls_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      // Capture the incoming transaction
      if (ctl.latch) begin
         cmd_in    = req_tuser[wls_pkg::CMD_W-1:0];
         lsel_in   = req_tuser[wls_pkg::CMD_W];
         idx_in    = req_tdata[wls_pkg::REQ_IDX_LSB +: wls_pkg::INDEX_W];
         weight_in = req_tdata[wls_pkg::REQ_WEIGHT_LSB +: wls_pkg::WEIGHT_IN_W];
         rand_in   = req_tdata[wls_pkg::REQ_RAND_LSB +: wls_pkg::RAND_W];
      end

      // Advance the walk counter and the running sum
      if (ctl.walk_clear) begin
         walk_in = '0;
         acc_in  = '0;
      end else begin
         if (ctl.rd_issue) begin
            walk_in   = walk_ff + wls_pkg::count_type'(1);
            rd_idx_in = walk_ff;
         end
         if (rd_pend_ff) begin
            acc_in = acc_next;
         end
      end

      // Round robin position
      if (ctl.pos_from_rem) begin
         pos_in = (rem_next == active_count) ? '0 : wls_pkg::entry_type'(rem_next);
      end else if (ctl.pos_restore) begin
         if (active_count != '0 && wls_pkg::count_type'(idx_ff) < active_count) begin
            pos_in = (idx_next == active_count) ? '0 : wls_pkg::entry_type'(idx_next);
         end
      end

      // Result of the current transaction
      if (ctl.res_miss) begin
         res_valid_in = 1'b0;
         res_list_in  = 1'b0;
         res_index_in = '0;
      end else if (ctl.res_rem) begin
         res_valid_in = 1'b1;
         res_list_in  = active_weighted;
         res_index_in = wls_pkg::index_type'(mod_rem);
      end else if (ctl.res_hit) begin
         res_valid_in = 1'b1;
         res_list_in  = active_weighted;
         res_index_in = wls_pkg::index_type'(rd_idx_ff);
      end

      // Output register: load a result, drop it once taken
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pick_in  = res_valid_ff;
         rsp_list_in  = res_list_ff;
         rsp_index_in = res_index_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         pcount_ff    <= '0;
         wcount_ff    <= '0;
         pos_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         pcount_ff    <= pcount_in;
         wcount_ff    <= wcount_in;
         pos_ff       <= pos_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      lsel_ff      <= lsel_in;
      idx_ff       <= idx_in;
      weight_ff    <= weight_in;
      rand_ff      <= rand_in;
      walk_ff      <= walk_in;
      rd_idx_ff    <= rd_idx_in;
      acc_ff       <= acc_in;
      res_valid_ff <= res_valid_in;
      res_list_ff  <= res_list_in;
      res_index_ff <= res_index_in;
      rsp_pick_ff  <= rsp_pick_in;
      rsp_list_ff  <= rsp_list_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = wls_pkg::rsp_data_type'(rsp_index_ff);
   assign rsp_tuser  = {rsp_list_ff, rsp_pick_ff};

endmodule

### rtl/wls_ctrl.sv
module wls_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  wls_pkg::ctl_status_type stat,
   output wls_pkg::ctl_cmd_type    ctl
);

   wls_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wls_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = wls_pkg::ST_DECODE;
            end
         end
         wls_pkg::ST_DECODE: begin
            case (stat.cmd)
               wls_pkg::CMD_SELECT: begin
                  if (stat.count_zero) begin
                     state_in = wls_pkg::ST_RESULT;
                  end else if (stat.mode == wls_pkg::MODE_WEIGHTED) begin
                     state_in = wls_pkg::ST_SUM;
                  end else begin
                     state_in = wls_pkg::ST_MOD_C;
                  end
               end
               default: state_in = wls_pkg::ST_RESULT;
            endcase
         end
         wls_pkg::ST_SUM: begin
            if (stat.walk_last) begin
               state_in = wls_pkg::ST_SUM_LAST;
            end
         end
         wls_pkg::ST_SUM_LAST: state_in = wls_pkg::ST_CHECK;
         wls_pkg::ST_CHECK: begin
            state_in = stat.total_zero ? wls_pkg::ST_RESULT : wls_pkg::ST_MOD_W;
         end
         wls_pkg::ST_MOD_W: begin
            if (!stat.mod_busy) begin
               state_in = wls_pkg::ST_WALK;
            end
         end
         wls_pkg::ST_WALK: begin
            if (stat.hit) begin
               state_in = wls_pkg::ST_RESULT;
            end else if (stat.walk_last) begin
               state_in = wls_pkg::ST_WALK_LAST;
            end
         end
         wls_pkg::ST_WALK_LAST: state_in = wls_pkg::ST_RESULT;
         wls_pkg::ST_MOD_C: begin
            if (!stat.mod_busy) begin
               state_in = wls_pkg::ST_RESULT;
            end
         end
         wls_pkg::ST_RESULT: begin
            if (stat.out_free) begin
               state_in = wls_pkg::ST_IDLE;
            end
         end
         default: state_in = wls_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      ctl         = '0;
      ctl.mod_src = wls_pkg::MOD_RAND_COUNT;
      req_tready  = 1'b0;
      case (state_ff)
         wls_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.latch      = 1'b1;
               ctl.walk_clear = 1'b1;
            end
         end
         wls_pkg::ST_DECODE: begin
            case (stat.cmd)
               wls_pkg::CMD_WRITE: begin
                  ctl.ram_write = 1'b1;
                  ctl.res_miss  = 1'b1;
               end
               wls_pkg::CMD_SELECT: begin
                  if (stat.count_zero) begin
                     ctl.res_miss = 1'b1;
                  end else if (stat.mode == wls_pkg::MODE_SEQ) begin
                     ctl.mod_start = 1'b1;
                     ctl.mod_src   = wls_pkg::MOD_POS_COUNT;
                  end else if (stat.mode != wls_pkg::MODE_WEIGHTED) begin
                     ctl.mod_start = 1'b1;
                     ctl.mod_src   = wls_pkg::MOD_RAND_COUNT;
                  end
               end
               wls_pkg::CMD_RESTORE: begin
                  ctl.pos_restore = 1'b1;
                  ctl.res_miss    = 1'b1;
               end
               default: ctl.res_miss = 1'b1;
            endcase
         end
         wls_pkg::ST_SUM: ctl.rd_issue = 1'b1;
         wls_pkg::ST_SUM_LAST: ;
         wls_pkg::ST_CHECK: begin
            if (stat.total_zero) begin
               ctl.res_miss = 1'b1;
            end else begin
               ctl.mod_start  = 1'b1;
               ctl.mod_src    = wls_pkg::MOD_RAND_TOTAL;
               ctl.walk_clear = 1'b1;
            end
         end
         wls_pkg::ST_MOD_W: ;
         wls_pkg::ST_WALK: begin
            if (stat.hit) begin
               ctl.res_hit = 1'b1;
            end else begin
               ctl.rd_issue = 1'b1;
            end
         end
         wls_pkg::ST_WALK_LAST: begin
            if (stat.hit) begin
               ctl.res_hit = 1'b1;
            end else begin
               ctl.res_miss = 1'b1;
            end
         end
         wls_pkg::ST_MOD_C: begin
            if (!stat.mod_busy) begin
               ctl.res_rem      = 1'b1;
               ctl.pos_from_rem = (stat.mode == wls_pkg::MODE_SEQ);
            end
         end
         wls_pkg::ST_RESULT: ctl.rsp_load = stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/weighted_lottery_selector_unit.sv
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tdata: entry_index, entry_weight, random_word
//                                             tuser: cmd, list_select
// rsp      out        rsp_tvalid/rsp_tready   tdata: picked_index; tuser: pick_valid, picked_list
// csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// One transaction at a time. Write, restore, unknown and empty-list selects go from decode
// straight to the result; uniform and sequential selects wait on the 32-step bit-serial
// remainder unit. Weighted selects end after the sum on a zero total: one table read port
// sums, then walks the active list.
// Reset is synchronous and active high; the weight table is not cleared. A finished result
// waits in the output register; a stalled output holds the controller only at its next result.
`include "assert_macros.svh"

module weighted_lottery_selector_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [5:0] entry_index, [21:6] entry_weight, [53:22] random_word, [55:54] zero
   input  logic [wls_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd, [2] list_select
   input  logic [wls_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [5:0] picked_index, [7:6] zero
   output logic [wls_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] pick_valid, [1] picked_list
   output logic [wls_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wls_pkg::CSR_DATA_W-1:0]   csr_data
);

   wls_pkg::ctl_cmd_type    ctl;
   wls_pkg::ctl_status_type stat;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   wls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   wls_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ctl        (ctl),
      .stat       (stat)
   );

   // Checks
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, ctl.rsp_load, stat.out_free)
   `ASSERT_NEXT(a_mod_starts, clock, reset, ctl.mod_start, stat.mod_busy)
   `ASSERT_IMPLIES(a_miss_is_zero, clock, reset, rsp_tvalid && !rsp_tuser[0],
                   rsp_tuser[1] == 1'b0 && rsp_tdata == '0)

endmodule
